FILE: rtl/core/dfs_pkg.sv
`default_nettype none
package dfs_pkg;

  localparam int FIRST_FIELD_DEPTH_DEF = 62;
  localparam int SELECT_BITS           = 128;
  localparam int OPEN_RANGE_LIMIT      = 1024;
  localparam int CMD_QUEUE_DEPTH       = 2;

  localparam int LEN_W = 6;
  localparam int IDX_W = 11;
  localparam int POS_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0]       NEWLINE_BYTE  = 8'd10;
  localparam logic [7:0]       DELIM_RESET   = 8'd9;
  localparam logic [IDX_W-1:0] INDEX_MAX     = 11'd2047;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_EOS  = 1'b1;
  localparam logic MODE_FIELD = 1'b0;
  localparam logic MODE_CHAR  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CUT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_UNDELIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_FROM   = 3'd5;

  typedef struct packed {
    logic             cut_mode;
    logic [7:0]       delimiter;
    logic             skip_undelimited;
    logic [63:0]      select_low;
    logic [63:0]      select_high;
    logic [IDX_W-1:0] open_from;
  } cfg_t;

  // One queued command: flush of the first-field store, then delimiter,
  // data byte and newline, each optional, in that order.
  typedef struct packed {
    logic [LEN_W-1:0] flush_len;
    logic             delim_en;
    logic             byte_en;
    logic             nl_en;
    logic [7:0]       delim;
    logic [7:0]       data;
    logic             ovf;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic flush_done;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FLUSH_RD,
    BK_FLUSH_WR,
    BK_TAIL
  } back_state_t;

  function automatic logic sel_pos(input cfg_t cfg, input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] k;
    logic [127:0]     map;
    logic             hit;
    k   = pos - POS_W'(1);
    map = {cfg.select_high, cfg.select_low};
    hit = 1'b0;
    if (pos >= POS_W'(1) && pos <= POS_W'(SELECT_BITS))
      hit = map[k[6:0]];
    if (cfg.open_from != '0 && pos >= {1'b0, cfg.open_from} &&
        pos <= POS_W'(OPEN_RANGE_LIMIT))
      hit = 1'b1;
    return hit;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/delimited_field_selector_core.sv
// Path: commands go from the front end through the command queue to the back end.
// Throughput: items without results go at one per cycle while the command queue has room;
// the back end loads each command, then emits any stored first-field bytes, each after a
// registered store read, and then its delimiter, data and newline bytes;
// input also holds while a first-field flush is pending.
// Reset: synchronous rst_n clears line state, queue, back-end state, output valid and configuration only.
`default_nettype none
module delimited_field_selector_core
  import dfs_pkg::*;
#(
  parameter int FIRST_FIELD_DEPTH = FIRST_FIELD_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] in_byte
  input  wire logic                  in_tuser,   // [0] func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic                       out_tlast,
  output logic                       out_tuser,  // [0] overflow
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers; writes to an unused index drop silently.
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_CUT_MODE:     cfg_nxt.cut_mode         = cfg_wdata[0];
        CFG_DELIMITER:    cfg_nxt.delimiter        = cfg_wdata[7:0];
        CFG_SKIP_UNDELIM: cfg_nxt.skip_undelimited = cfg_wdata[0];
        CFG_SELECT_LOW:   cfg_nxt.select_low       = cfg_wdata;
        CFG_SELECT_HIGH:  cfg_nxt.select_high      = cfg_wdata;
        CFG_OPEN_FROM:    cfg_nxt.open_from        = cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= {MODE_FIELD, DELIM_RESET, 1'b0, 64'd0, 64'd0, {IDX_W{1'b0}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: parse the byte, track the line, write field 1 into the store
  // and post one command per item that causes output.
  logic         q_full, q_push, q_pop, q_valid;
  cmd_t         q_cmd_in, q_cmd_out;
  store_wr_t    st_wr;
  back_status_t bk_status;

  dfs_front #(
    .FIRST_FIELD_DEPTH(FIRST_FIELD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_byte   (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd_in),
    .st_wr     (st_wr),
    .bk_status (bk_status)
  );

  // Short command queue: decouples parsing from byte emission.
  dfs_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_cmd_out)
  );

  // Back end: drain the store and emit delimiter, data and newline bytes
  // through the output register.
  dfs_back #(
    .FIRST_FIELD_DEPTH(FIRST_FIELD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .st_wr     (st_wr),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd_out),
    .q_pop     (q_pop),
    .bk_status (bk_status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_ovf   (out_tuser)
  );

endmodule
`default_nettype wire

FILE: rtl/core/dfs_cmd_queue.sv
`default_nettype none
module dfs_cmd_queue
  import dfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      data
);

  localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

  cmd_t          slot_r [CMD_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(CMD_QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (!push && pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

FILE: rtl/core/dfs_front.sv
`default_nettype none
module dfs_front
  import dfs_pkg::*;
#(
  parameter int FIRST_FIELD_DEPTH = FIRST_FIELD_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_func,
  input  wire logic [7:0]   in_byte,
  input  wire logic         q_full,
  output logic              q_push,
  output cmd_t              q_cmd,
  output store_wr_t         st_wr,
  input  wire back_status_t bk_status
);

  localparam int LW = $clog2(FIRST_FIELD_DEPTH + 1);

  logic [IDX_W-1:0] index_count_r, index_count_nxt;
  logic             emitted_any_r, emitted_any_nxt;
  logic             delim_seen_r, delim_seen_nxt;
  logic             line_open_r, line_open_nxt;
  logic [LW-1:0]    ff_len_r, ff_len_nxt;
  logic             ovf_seen_r, ovf_seen_nxt;
  logic             flush_pend_r, flush_pend_nxt;

  logic             fire;
  logic             sel1, sel_pos_hit;
  logic             is_delim, end_line, em1;
  logic [IDX_W-1:0] idx_bump;
  logic [POS_W-1:0] pos;
  cmd_t             cmd;

  // Hold input while the store is still being drained: a new line would
  // overwrite entries the back end has not read yet.
  assign in_ready = !q_full && !flush_pend_r;
  assign fire     = in_valid && in_ready;

  assign is_delim = (in_byte == cfg.delimiter);
  assign idx_bump = (index_count_r < INDEX_MAX) ? index_count_r + IDX_W'(1) : index_count_r;
  assign sel1     = sel_pos(cfg, POS_W'(1));
  assign pos      = (cfg.cut_mode == MODE_FIELD && is_delim) ?
                    {1'b0, idx_bump} + POS_W'(1) : {1'b0, index_count_r} + POS_W'(1);
  assign sel_pos_hit = sel_pos(cfg, pos);
  assign end_line = (in_func == FUNC_EOS) ? line_open_r : (in_byte == NEWLINE_BYTE);
  assign em1      = emitted_any_r || (!delim_seen_r && sel1);

  always_comb begin
    index_count_nxt = index_count_r;
    emitted_any_nxt = emitted_any_r;
    delim_seen_nxt  = delim_seen_r;
    line_open_nxt   = line_open_r;
    ff_len_nxt      = ff_len_r;
    ovf_seen_nxt    = ovf_seen_r;
    cmd             = '0;
    cmd.delim       = cfg.delimiter;
    cmd.data        = in_byte;
    st_wr           = '0;
    st_wr.addr      = LEN_W'(ff_len_r);
    st_wr.data      = in_byte;

    if (fire) begin
      if (end_line) begin
        cmd.ovf = ovf_seen_r;
        if (cfg.cut_mode == MODE_FIELD && !delim_seen_r) begin
          if (!cfg.skip_undelimited) begin
            cmd.flush_len = sel1 ? LEN_W'(ff_len_r) : '0;
            cmd.nl_en     = 1'b1;
          end
        end else begin
          cmd.nl_en = 1'b1;
        end
        index_count_nxt = '0;
        emitted_any_nxt = 1'b0;
        delim_seen_nxt  = 1'b0;
        line_open_nxt   = 1'b0;
        ff_len_nxt      = '0;
        ovf_seen_nxt    = 1'b0;
      end else if (in_func == FUNC_DATA) begin
        line_open_nxt = 1'b1;
        if (cfg.cut_mode == MODE_CHAR) begin
          if (sel_pos_hit) begin
            cmd.delim_en    = emitted_any_r;
            cmd.byte_en     = 1'b1;
            emitted_any_nxt = 1'b1;
          end
          index_count_nxt = idx_bump;
        end else if (is_delim) begin
          if (!delim_seen_r) begin
            delim_seen_nxt = 1'b1;
            if (sel1) cmd.flush_len = LEN_W'(ff_len_r);
          end
          index_count_nxt = idx_bump;
          emitted_any_nxt = em1;
          if (sel_pos_hit) begin
            cmd.delim_en    = em1;
            emitted_any_nxt = 1'b1;
          end
        end else if (!delim_seen_r) begin
          if (sel1) begin
            if (ff_len_r < LW'(FIRST_FIELD_DEPTH)) begin
              st_wr.en   = 1'b1;
              ff_len_nxt = ff_len_r + LW'(1);
            end else begin
              ovf_seen_nxt = 1'b1;
            end
          end
        end else if (sel_pos_hit) begin
          cmd.byte_en = 1'b1;
        end
        cmd.ovf = ovf_seen_nxt;
      end
    end
  end

  assign q_cmd  = cmd;
  assign q_push = fire && (cmd.flush_len != '0 || cmd.delim_en || cmd.byte_en || cmd.nl_en);

  always_comb begin
    flush_pend_nxt = flush_pend_r;
    if (bk_status.flush_done) flush_pend_nxt = 1'b0;
    if (q_push && cmd.flush_len != '0) flush_pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_count_r <= '0;
      emitted_any_r <= 1'b0;
      delim_seen_r  <= 1'b0;
      line_open_r   <= 1'b0;
      ff_len_r      <= '0;
      ovf_seen_r    <= 1'b0;
      flush_pend_r  <= 1'b0;
    end else begin
      index_count_r <= index_count_nxt;
      emitted_any_r <= emitted_any_nxt;
      delim_seen_r  <= delim_seen_nxt;
      line_open_r   <= line_open_nxt;
      ff_len_r      <= ff_len_nxt;
      ovf_seen_r    <= ovf_seen_nxt;
      flush_pend_r  <= flush_pend_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dfs_back.sv
`default_nettype none
module dfs_back
  import dfs_pkg::*;
#(
  parameter int FIRST_FIELD_DEPTH = FIRST_FIELD_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire store_wr_t  st_wr,
  input  wire logic       q_valid,
  input  wire cmd_t       q_cmd,
  output logic            q_pop,
  output back_status_t    bk_status,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_ovf
);

  localparam int LW = $clog2(FIRST_FIELD_DEPTH + 1);
  localparam int AW = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;

  logic [7:0] store_mem [FIRST_FIELD_DEPTH];

  back_state_t state_r, state_nxt;
  cmd_t        cur_r, cur_nxt;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic [7:0]  rd_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_ovf_r, out_ovf_nxt;

  logic [LEN_W-1:0] len_m1;
  logic          slot_free, ptr_at_end, tail_any;

  assign slot_free  = !out_valid_r || out_ready;
  assign len_m1     = cur_r.flush_len - LEN_W'(1);
  assign ptr_at_end = (ptr_r == len_m1[LW-1:0]);
  assign tail_any   = cur_r.delim_en || cur_r.byte_en || cur_r.nl_en;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:     if (q_valid) state_nxt = (q_cmd.flush_len != '0) ? BK_FLUSH_RD : BK_TAIL;
      BK_FLUSH_RD: state_nxt = BK_FLUSH_WR;
      BK_FLUSH_WR: begin
        if (slot_free) begin
          if (!ptr_at_end) state_nxt = BK_FLUSH_RD;
          else state_nxt = tail_any ? BK_TAIL : BK_IDLE;
        end
      end
      BK_TAIL: begin
        if (slot_free && ((cur_r.delim_en ? 1 : 0) + (cur_r.byte_en ? 1 : 0) +
                          (cur_r.nl_en ? 1 : 0)) <= 1)
          state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop         = 1'b0;
    cur_nxt       = cur_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    bk_status     = '0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          ptr_nxt = '0;
        end
      end
      BK_FLUSH_WR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_last_nxt  = ptr_at_end && !tail_any;
          out_ovf_nxt   = cur_r.ovf;
          ptr_nxt       = ptr_r + LW'(1);
          bk_status.flush_done = ptr_at_end;
        end
      end
      BK_TAIL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = cur_r.ovf;
          if (cur_r.delim_en) begin
            out_byte_nxt     = cur_r.delim;
            cur_nxt.delim_en = 1'b0;
            out_last_nxt     = !cur_r.byte_en && !cur_r.nl_en;
          end else if (cur_r.byte_en) begin
            out_byte_nxt    = cur_r.data;
            cur_nxt.byte_en = 1'b0;
            out_last_nxt    = !cur_r.nl_en;
          end else begin
            out_byte_nxt  = NEWLINE_BYTE;
            cur_nxt.nl_en = 1'b0;
            out_last_nxt  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    ptr_r      <= ptr_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) store_mem[st_wr.addr[AW-1:0]] <= st_wr.data;
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_FLUSH_RD) rd_data_r <= store_mem[ptr_r[AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

endmodule
`default_nettype wire
